/* src/ypst_pkg.sv */
package ypst_pkg;

	localparam int NumWords = 10;
	localparam int NumSpecial = 6;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
		logic       empty_text;
	} beat_t;

	// Words are right-justified in the vector; the first character is the highest byte that the word occupies.
	localparam logic [39:0] WORD_STR [NumWords] = '{
		40'("~"), 40'("null"), 40'("Null"), 40'("NULL"), 40'("true"),
		40'("True"), 40'("TRUE"), 40'("false"), 40'("False"), 40'("FALSE")
	};

	localparam logic [2:0] WORD_LEN [NumWords] = '{
		3'd1, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5
	};

	localparam logic [31:0] SPECIAL_STR [NumSpecial] = '{
		32'(".inf"), 32'(".Inf"), 32'(".INF"), 32'(".nan"), 32'(".NaN"), 32'(".NAN")
	};

	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_DOT   = 8'h2E;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_SEVEN = 8'h37;
	localparam logic [7:0] CHR_NINE  = 8'h39;
	localparam logic [7:0] CHR_UP_A  = 8'h41;
	localparam logic [7:0] CHR_UP_E  = 8'h45;
	localparam logic [7:0] CHR_UP_F  = 8'h46;
	localparam logic [7:0] CHR_UP_O  = 8'h4F;
	localparam logic [7:0] CHR_UP_X  = 8'h58;
	localparam logic [7:0] CHR_LO_A  = 8'h61;
	localparam logic [7:0] CHR_LO_E  = 8'h65;
	localparam logic [7:0] CHR_LO_F  = 8'h66;
	localparam logic [7:0] CHR_LO_O  = 8'h6F;
	localparam logic [7:0] CHR_LO_X  = 8'h78;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CHR_ZERO) && (b <= CHR_NINE);
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_digit(b) || ((b >= CHR_LO_A) && (b <= CHR_LO_F)) ||
			((b >= CHR_UP_A) && (b <= CHR_UP_F));
	endfunction

	function automatic logic is_sign(input logic [7:0] b);
		return (b == CHR_PLUS) || (b == CHR_MINUS);
	endfunction

	// Character at position p of word w of length len; only meaningful for p < len.
	function automatic logic [7:0] word_char(input logic [39:0] w, input logic [2:0] len,
			input logic [2:0] p);
		logic [2:0] r;
		logic [39:0] sh;
		r = len - 3'd1 - p;
		sh = w >> {r, 3'b000};
		return sh[7:0];
	endfunction

	function automatic logic [7:0] special_char(input logic [31:0] w, input logic [1:0] p);
		logic [1:0] r;
		logic [31:0] sh;
		r = 2'd3 - p;
		sh = w >> {r, 3'b000};
		return sh[7:0];
	endfunction

endpackage

/* src/ypst_recog.sv */
module ypst_recog (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  ypst_pkg::beat_t beat,
	output logic           hit
);
	import ypst_pkg::*;

	typedef enum logic [3:0] {
		PH_START, PH_SIGN, PH_INT, PH_DOTONLY, PH_FRAC,
		PH_EXP, PH_EXPSIGN, PH_EXPDIG, PH_DEAD
	} phase_t;

	logic [2:0]            pos_q;
	logic [NumWords-1:0]   word_q;
	logic [NumSpecial-1:0] special_q;
	logic                  sign_q;
	logic                  hex_q;
	logic                  oct_q;
	phase_t                phase_q;

	logic [NumWords-1:0]   word_n;
	logic [NumSpecial-1:0] special_n;
	logic                  sign_n;
	logic                  hex_n;
	logic                  oct_n;
	phase_t                phase_n;
	logic [2:0]            idx;
	logic [3:0]            pos_inc;
	logic                  word_hit;
	logic                  dig;
	logic                  sgn;
	logic                  ex;
	logic [7:0]            b;

	assign b   = beat.text_byte;
	assign dig = is_digit(b);
	assign sgn = is_sign(b);
	assign ex  = (b == CHR_LO_E) || (b == CHR_UP_E);
	assign pos_inc = {1'b0, pos_q} + 4'd1;

	always_comb begin
		for (int k = 0; k < NumWords; k++) begin
			word_n[k] = word_q[k] && (pos_q < WORD_LEN[k]) &&
				(word_char(WORD_STR[k], WORD_LEN[k], pos_q) == b);
		end

		// A leading sign is skipped by the inf/nan match; later bytes index past it.
		sign_n = sign_q;
		special_n = special_q;
		idx = pos_q - {2'b00, sign_q};
		if ((pos_q == 3'd0) && sgn) begin
			sign_n = 1'b1;
		end else begin
			for (int k = 0; k < NumSpecial; k++) begin
				special_n[k] = special_q[k] && !idx[2] &&
					(special_char(SPECIAL_STR[k], idx[1:0]) == b);
			end
		end

		if (pos_q == 3'd0) begin
			hex_n = (b == CHR_ZERO);
			oct_n = (b == CHR_ZERO);
		end else if (pos_q == 3'd1) begin
			hex_n = hex_q && ((b == CHR_LO_X) || (b == CHR_UP_X));
			oct_n = oct_q && ((b == CHR_LO_O) || (b == CHR_UP_O));
		end else begin
			hex_n = hex_q && is_hex(b);
			oct_n = oct_q && (b >= CHR_ZERO) && (b <= CHR_SEVEN);
		end

		unique case (phase_q)
			PH_START:   phase_n = sgn ? PH_SIGN : dig ? PH_INT :
				(b == CHR_DOT) ? PH_DOTONLY : PH_DEAD;
			PH_SIGN:    phase_n = dig ? PH_INT : (b == CHR_DOT) ? PH_DOTONLY : PH_DEAD;
			PH_INT:     phase_n = dig ? PH_INT : (b == CHR_DOT) ? PH_FRAC :
				ex ? PH_EXP : PH_DEAD;
			PH_DOTONLY: phase_n = dig ? PH_FRAC : PH_DEAD;
			PH_FRAC:    phase_n = dig ? PH_FRAC : ex ? PH_EXP : PH_DEAD;
			PH_EXP:     phase_n = sgn ? PH_EXPSIGN : dig ? PH_EXPDIG : PH_DEAD;
			PH_EXPSIGN: phase_n = dig ? PH_EXPDIG : PH_DEAD;
			PH_EXPDIG:  phase_n = dig ? PH_EXPDIG : PH_DEAD;
			default:    phase_n = PH_DEAD;
		endcase

		word_hit = 1'b0;
		for (int k = 0; k < NumWords; k++) begin
			if (word_n[k] && (pos_inc == {1'b0, WORD_LEN[k]})) begin
				word_hit = 1'b1;
			end
		end

		hit = beat.empty_text || word_hit ||
			((special_n != '0) && (pos_inc == (4'd4 + {3'b000, sign_n}))) ||
			((pos_q >= 3'd2) && (hex_n || oct_n)) ||
			(phase_n == PH_INT) || (phase_n == PH_FRAC) || (phase_n == PH_EXPDIG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			word_q    <= '1;
			special_q <= '1;
			sign_q    <= 1'b0;
			hex_q     <= 1'b0;
			oct_q     <= 1'b0;
			phase_q   <= PH_START;
		end else if (step) begin
			if (beat.empty_text || beat.last_byte) begin
				pos_q     <= '0;
				word_q    <= '1;
				special_q <= '1;
				sign_q    <= 1'b0;
				hex_q     <= 1'b0;
				oct_q     <= 1'b0;
				phase_q   <= PH_START;
			end else begin
				if (pos_q != 3'd7) begin
					pos_q <= pos_inc[2:0];
				end
				word_q    <= word_n;
				special_q <= special_n;
				sign_q    <= sign_n;
				hex_q     <= hex_n;
				oct_q     <= oct_n;
				phase_q   <= phase_n;
			end
		end
	end

endmodule

/* src/yaml_plain_scalar_type_check.sv */
// The result for a text is registered when its final byte (or empty-text beat) is accepted,
// and is valid in the next cycle. Throughput: one byte per cycle while in_ready is high; the input
// stalls only while a held result waits on out_ready. All recognizers update in parallel from a
// single set of state registers, and the result register drains while the next text streams in.
// Reset (arst_n low) returns the recognizers to the start of a text and empties the result register.
module yaml_plain_scalar_type_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       last_byte,
	input  logic       empty_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       needs_quoting
);
	import ypst_pkg::*;

	beat_t beat;
	logic  accept;
	logic  hit;
	logic  out_valid_q;
	logic  needs_quoting_q;

	assign beat     = '{text_byte: text_byte, last_byte: last_byte, empty_text: empty_text};
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	ypst_recog u_recog (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.beat   (beat),
		.hit    (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && (last_byte || empty_text)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (last_byte || empty_text)) begin
			needs_quoting_q <= hit;
		end
	end

	assign out_valid     = out_valid_q;
	assign needs_quoting = needs_quoting_q;

`ifndef SYNTHESIS
	a_empty_quotes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && empty_text |=> out_valid && needs_quoting)
		else $error("empty text beat did not produce a quoted result");

	a_final_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (last_byte || empty_text) |=> out_valid)
		else $error("final beat did not produce a result");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled while the result register could drain");
`endif

endmodule

/* verif/tb_yaml_plain_scalar_type_check.sv */
module tb_yaml_plain_scalar_type_check;
	timeunit 1ns;
	timeprecision 1ps;

	import ypst_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BEATS = 1550;
	localparam int MAX_REPORTS = 10;

	typedef logic [7:0] byte_q_t[$];

	typedef enum logic [3:0] {
		NUM_START, NUM_SIGN, NUM_INT, NUM_DOT_ONLY, NUM_FRAC,
		NUM_EXP, NUM_EXP_SIGN, NUM_EXP_DIG, NUM_DEAD
	} num_state_t;

	typedef enum {ROW_TEXT, ROW_RAW, ROW_PARTIAL, ROW_EMPTY} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		string      txt;
		logic [7:0] raw;
		bit         typed;
		bit         want;
	} row_t;

	typedef struct {
		bit typed;
		bit want;
	} fixed_answer_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] text_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       empty_text = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       needs_quoting;

	// Predictor state for the text that is streaming in.
	logic [2:0]  n_chars;
	logic [9:0]  word_live;
	logic [5:0]  special_live;
	bit          lead_sign;
	bit          hex_live;
	bit          oct_live;
	num_state_t  num_state;

	string quote_words[10] = '{"~", "null", "Null", "NULL", "true", "True", "TRUE",
		"false", "False", "FALSE"};
	string special_words[6] = '{".inf", ".Inf", ".INF", ".nan", ".NaN", ".NAN"};

	bit            quoting_due[$];
	fixed_answer_t fixed_answer_q[$];
	int            faults = 0;
	int            cycles = 0;
	int            beats_sent = 0;
	int            gap_pct = 8;
	int            stall_pct = 8;

	row_t directed_rows[11] = '{
		'{ROW_EMPTY,   "",          8'h00, 1'b1, 1'b1},
		'{ROW_TEXT,    "~",         8'h00, 1'b1, 1'b1},
		'{ROW_TEXT,    "False",     8'h00, 1'b1, 1'b1},
		'{ROW_TEXT,    "0x9f",      8'h00, 1'b1, 1'b1},
		'{ROW_TEXT,    "0O7",       8'h00, 1'b1, 1'b1},
		'{ROW_TEXT,    "-.Inf",     8'h00, 1'b1, 1'b1},
		'{ROW_RAW,     "",          8'hFF, 1'b1, 1'b0},
		'{ROW_RAW,     "",          8'h00, 1'b1, 1'b0},
		'{ROW_PARTIAL, "5",         8'h00, 1'b0, 1'b0},
		'{ROW_EMPTY,   "",          8'h00, 1'b1, 1'b1},
		'{ROW_TEXT,    "+123456.7", 8'h00, 1'b0, 1'b0}
	};

	yaml_plain_scalar_type_check uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.last_byte    (last_byte),
		.empty_text   (empty_text),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.needs_quoting(needs_quoting)
	);

	always #5 clk = ~clk;

	function automatic void restart_text();
		n_chars = 3'd0;
		word_live = '1;
		special_live = '1;
		lead_sign = 1'b0;
		hex_live = 1'b0;
		oct_live = 1'b0;
		num_state = NUM_START;
	endfunction

	// Advances the recognizers by one beat; returns 1 when the beat closes a text,
	// with the quoting decision in hit.
	function automatic bit scalar_quoting_step(input logic [7:0] b, input logic l,
			input logic e, output bit hit);
		int pos;
		int idx;
		bit dig;
		bit sgn;
		bit ex;
		hit = 1'b0;
		if (e) begin
			restart_text();
			hit = 1'b1;
			return 1'b1;
		end
		pos = n_chars;
		dig = (b >= "0") && (b <= "9");
		sgn = (b == CHR_PLUS) || (b == CHR_MINUS);
		ex = (b == "e") || (b == "E");

		for (int k = 0; k < 10; k++) begin
			if (word_live[k]) begin
				if (pos >= quote_words[k].len())
					word_live[k] = 1'b0;
				else if (8'(quote_words[k][pos]) != b)
					word_live[k] = 1'b0;
			end
		end

		// A leading sign shifts the inf/nan words one place to the right.
		if (pos == 0 && sgn) begin
			lead_sign = 1'b1;
		end else begin
			idx = pos - lead_sign;
			for (int k = 0; k < 6; k++) begin
				if (special_live[k]) begin
					if (idx >= 4)
						special_live[k] = 1'b0;
					else if (8'(special_words[k][idx]) != b)
						special_live[k] = 1'b0;
				end
			end
		end

		if (pos == 0) begin
			hex_live = (b == "0");
			oct_live = (b == "0");
		end else if (pos == 1) begin
			hex_live = hex_live && (b == "x" || b == "X");
			oct_live = oct_live && (b == "o" || b == "O");
		end else begin
			hex_live = hex_live && (dig || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
			oct_live = oct_live && (b >= "0" && b <= "7");
		end

		case (num_state)
			NUM_START: num_state = sgn ? NUM_SIGN : dig ? NUM_INT :
				(b == CHR_DOT) ? NUM_DOT_ONLY : NUM_DEAD;
			NUM_SIGN: num_state = dig ? NUM_INT : (b == CHR_DOT) ? NUM_DOT_ONLY : NUM_DEAD;
			NUM_INT: num_state = dig ? NUM_INT : (b == CHR_DOT) ? NUM_FRAC :
				ex ? NUM_EXP : NUM_DEAD;
			NUM_DOT_ONLY: num_state = dig ? NUM_FRAC : NUM_DEAD;
			NUM_FRAC: num_state = dig ? NUM_FRAC : ex ? NUM_EXP : NUM_DEAD;
			NUM_EXP: num_state = sgn ? NUM_EXP_SIGN : dig ? NUM_EXP_DIG : NUM_DEAD;
			NUM_EXP_SIGN, NUM_EXP_DIG: num_state = dig ? NUM_EXP_DIG : NUM_DEAD;
			default: num_state = NUM_DEAD;
		endcase

		if (!l) begin
			if (n_chars != 3'd7)
				n_chars = n_chars + 3'd1;
			return 1'b0;
		end

		for (int k = 0; k < 10; k++)
			if (word_live[k] && pos + 1 == quote_words[k].len())
				hit = 1'b1;
		if (special_live != 0 && pos + 1 == 4 + lead_sign)
			hit = 1'b1;
		if (pos >= 2 && (hex_live || oct_live))
			hit = 1'b1;
		if (num_state == NUM_INT || num_state == NUM_FRAC || num_state == NUM_EXP_DIG)
			hit = 1'b1;
		restart_text();
		return 1'b1;
	endfunction

	function automatic byte_q_t bytes_of(input string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(8'(s[i]));
		return q;
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic l, input logic e);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		last_byte <= l;
		empty_text <= e;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
	endtask

	// An empty text that is closed goes out as a single empty-text beat.
	task automatic send_text(input byte_q_t txt, input bit close);
		if (txt.size() == 0) begin
			if (close)
				send_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
			return;
		end
		for (int i = 0; i < txt.size(); i++)
			send_beat(txt[i], close && (i == txt.size() - 1), 1'b0);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (quoting_due.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_yaml_plain_scalar_type_check: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin : scoreboard
		bit            closes;
		bit            want;
		bit            due;
		fixed_answer_t fixed;
		if (arst_n) begin
			// Results are checked before this edge's beat is predicted, so a result
			// can never be matched against an expectation of the same edge.
			if (out_valid && out_ready) begin
				if (quoting_due.size() == 0) begin
					faults++;
					if (faults <= MAX_REPORTS)
						$display("result beat with no expectation pending: needs_quoting=%0b",
							needs_quoting);
				end else begin
					due = quoting_due.pop_front();
					if (needs_quoting !== due) begin
						faults++;
						if (faults <= MAX_REPORTS)
							$display("needs_quoting mismatch: expected %0b, got %0b",
								due, needs_quoting);
					end
				end
			end
			if (in_valid && in_ready) begin
				closes = scalar_quoting_step(text_byte, last_byte, empty_text, want);
				if (closes) begin
					if (fixed_answer_q.size() != 0) begin
						fixed = fixed_answer_q.pop_front();
						if (fixed.typed)
							want = fixed.want;
					end
					quoting_due.push_back(want);
				end
			end
		end
	end

	initial begin : stimulus
		byte_q_t t;
		bit      abort;
		int      pick;
		int      texts;
		string   digit_pool;
		string   hex_pool;
		string   oct_pool;
		string   mix_pool;
		digit_pool = "0123456789";
		hex_pool = "0123456789abcdefABCDEFg";
		oct_pool = "012345678";
		mix_pool = "0123456789+-.eExXoO~nulNLtrueTRUfasFSEiIaAN";
		texts = 0;
		restart_text();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind != ROW_PARTIAL)
				fixed_answer_q.push_back('{directed_rows[i].typed, directed_rows[i].want});
			case (directed_rows[i].kind)
				ROW_TEXT: send_text(bytes_of(directed_rows[i].txt), 1'b1);
				ROW_RAW: begin
					t.delete();
					t.push_back(directed_rows[i].raw);
					send_text(t, 1'b1);
				end
				ROW_PARTIAL: send_text(bytes_of(directed_rows[i].txt), 1'b0);
				default: begin
					t.delete();
					send_text(t, 1'b1);
				end
			endcase
		end
		drain_results();

		while (beats_sent < RANDOM_BEATS + 32) begin
			if (beats_sent >= 700 && beats_sent < 1000) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = 8;
				stall_pct = 8;
			end
			t.delete();
			abort = 1'b0;
			pick = $urandom_range(99);
			if (pick < 15) begin
				t = bytes_of(quote_words[$urandom_range(9)]);
			end else if (pick < 25) begin
				if ($urandom_range(1))
					t.push_back($urandom_range(1) ? CHR_PLUS : CHR_MINUS);
				t = {t, bytes_of(special_words[$urandom_range(5)])};
			end else if (pick < 35) begin
				t.push_back(CHR_ZERO);
				t.push_back($urandom_range(1) ? CHR_LO_X : CHR_UP_X);
				repeat ($urandom_range(4))
					t.push_back(8'(hex_pool[$urandom_range(hex_pool.len() - 1)]));
			end else if (pick < 43) begin
				t.push_back(CHR_ZERO);
				t.push_back($urandom_range(1) ? CHR_LO_O : CHR_UP_O);
				repeat ($urandom_range(4))
					t.push_back(8'(oct_pool[$urandom_range(oct_pool.len() - 1)]));
			end else if (pick < 70) begin
				if ($urandom_range(3) == 0)
					t.push_back($urandom_range(1) ? CHR_PLUS : CHR_MINUS);
				repeat ($urandom_range(4))
					t.push_back(8'(digit_pool[$urandom_range(9)]));
				if ($urandom_range(1)) begin
					t.push_back(CHR_DOT);
					repeat ($urandom_range(4))
						t.push_back(8'(digit_pool[$urandom_range(9)]));
				end
				if ($urandom_range(2) == 0) begin
					t.push_back($urandom_range(1) ? CHR_LO_E : CHR_UP_E);
					if ($urandom_range(1))
						t.push_back($urandom_range(1) ? CHR_PLUS : CHR_MINUS);
					repeat ($urandom_range(3))
						t.push_back(8'(digit_pool[$urandom_range(9)]));
				end
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 12))
					t.push_back(8'($urandom_range(255)));
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 10))
					t.push_back(8'(mix_pool[$urandom_range(mix_pool.len() - 1)]));
			end else if (pick >= 95) begin
				abort = 1'b1;
				repeat ($urandom_range(5))
					t.push_back(8'(mix_pool[$urandom_range(mix_pool.len() - 1)]));
			end

			// A few well-formed texts get one byte corrupted to probe near misses.
			if (pick < 70 && t.size() != 0 && $urandom_range(99) < 15)
				t[$urandom_range(t.size() - 1)] = $urandom_range(1) ?
					8'(mix_pool[$urandom_range(mix_pool.len() - 1)]) : 8'($urandom_range(255));

			if (abort) begin
				send_text(t, 1'b0);
				t.delete();
			end
			send_text(t, 1'b1);

			texts++;
			if (texts == 60)
				drain_results();
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (faults == 0 && quoting_due.size() == 0)
			$display("tb_yaml_plain_scalar_type_check: PASS");
		else
			$display("tb_yaml_plain_scalar_type_check: FAIL");
		$finish;
	end

endmodule

/* files.f */
src/ypst_pkg.sv
src/ypst_recog.sv
src/yaml_plain_scalar_type_check.sv
verif/tb_yaml_plain_scalar_type_check.sv
